FILE: hw/rtl/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern search core
`default_nettype none

package wbps_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;
    localparam int MATCH_OFF_W = 32;
    localparam int CFG_PAT_BYTES = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 2'd3;

    typedef struct packed {
        logic advance;
        logic clear;
    } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wbps_cell.sv
// one cell of the partial match chain
`default_nettype none

module wbps_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wbps_pkg::scan_ctrl_t ctrl,
    input  wire logic [7:0]         data_byte,
    input  wire logic [7:0]         pat_byte,
    input  wire logic               wild,
    input  wire logic               prev_match,
    output logic                    hit,
    output logic                    match_reg
);
    import wbps_pkg::*;

    logic match_next;

    assign hit = prev_match && (wild || (data_byte == pat_byte));

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.clear)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            match_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wildcard_byte_pattern_search_core.sv
// top level of the wildcard byte pattern search core
// the result word is registered and valid in the cycle after the byte marked tlast is accepted
// throughput: one byte per cycle while the output register is empty or being drained, set by the step of the cell chain
// a byte is taken whenever the output register is empty or being drained
// reset: pattern registers, cell chain, byte counter and match latch clear to zero
// configuration writes are taken every cycle, no clearing pass after reset
`default_nettype none

module wildcard_byte_pattern_search_core #(
    parameter int PATTERN_MAX  = 16,
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wbps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,   // data_byte
    input  wire logic                              s_axis_tlast,   // last_byte
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [39:0]                            m_axis_tdata    // found, match_offset, pad
);
    import wbps_pkg::*;

    localparam int SEL_W = $clog2(PATTERN_MAX);
    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    logic [63:0]          pat_low_reg, pat_low_next;
    logic [63:0]          pat_high_reg, pat_high_next;
    logic [15:0]          wild_reg, wild_next;
    logic [LEN_W-1:0]     len_reg, len_next;

    logic [OFFSET_WIDTH-1:0] count_reg, count_next;
    logic                    seen_reg, seen_next;
    logic [OFFSET_WIDTH-1:0] first_reg, first_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg, found_next;
    logic [MATCH_OFF_W-1:0]  offset_reg, offset_next;

    scan_ctrl_t              ctrl;
    logic                    in_accept;
    logic [PATTERN_MAX-1:0]  hit_vec;
    logic [PATTERN_MAX-1:0]  chain_vec;
    logic [LEN_W-1:0]        len_m1;
    logic [SEL_W-1:0]        sel;
    logic                    len_ok;
    logic                    hit_now;
    logic [OFFSET_WIDTH-1:0] hit_off;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign ctrl.advance  = in_accept && !s_axis_tlast;
    assign ctrl.clear    = in_accept && s_axis_tlast;

    // cell chain
    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        logic [7:0] pat_b;
        logic       wild_b;
        logic       prev_m;

        if (j < 8)
        begin : g_lo
            assign pat_b  = pat_low_reg[8*j +: 8];
            assign wild_b = wild_reg[j];
        end
        else if (j < CFG_PAT_BYTES)
        begin : g_hi
            assign pat_b  = pat_high_reg[8*(j-8) +: 8];
            assign wild_b = wild_reg[j];
        end
        else
        begin : g_none
            assign pat_b  = 8'd0;
            assign wild_b = 1'b0;
        end

        if (j == 0)
        begin : g_head
            assign prev_m = 1'b1;
        end
        else
        begin : g_link
            assign prev_m = chain_vec[j-1];
        end

        wbps_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .data_byte  (s_axis_tdata),
            .pat_byte   (pat_b),
            .wild       (wild_b),
            .prev_match (prev_m),
            .hit        (hit_vec[j]),
            .match_reg  (chain_vec[j])
        );
    end

    // match detect and offset
    assign len_m1  = len_reg - LEN_W'(1);
    assign sel     = SEL_W'(len_m1);
    assign len_ok  = (len_reg != '0) && (32'(len_reg) <= PATTERN_MAX);
    assign hit_now = len_ok && hit_vec[sel];
    assign hit_off = count_reg - OFFSET_WIDTH'(len_m1);

    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        wild_next     = wild_reg;
        len_next      = len_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pat_low_next  = cfg_data;
                REG_PATTERN_HIGH: pat_high_next = cfg_data;
                REG_WILDCARD:     wild_next     = cfg_data[15:0];
                REG_LENGTH:       len_next      = cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        seen_next  = seen_reg;
        first_next = first_reg;
        if (in_accept && !seen_reg && hit_now)
        begin
            seen_next  = 1'b1;
            first_next = hit_off;
        end
        if (ctrl.clear)
        begin
            count_next = '0;
            seen_next  = 1'b0;
            first_next = '0;
        end
        else if (ctrl.advance && (count_reg != OFFSET_MAX))
        begin
            count_next = count_reg + OFFSET_WIDTH'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        found_next     = found_reg;
        offset_next    = offset_reg;
        if (ctrl.clear)
        begin
            out_valid_next = 1'b1;
            if (seen_reg)
            begin
                found_next  = 1'b1;
                offset_next = MATCH_OFF_W'(first_reg);
            end
            else if (hit_now)
            begin
                found_next  = 1'b1;
                offset_next = MATCH_OFF_W'(hit_off);
            end
            else
            begin
                found_next  = 1'b0;
                offset_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            wild_reg      <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pat_low_reg   <= pat_low_next;
            pat_high_reg  <= pat_high_next;
            wild_reg      <= wild_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, offset_reg, found_reg};

    // checks
    a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> m_axis_tvalid)
        else $error("no result word after last byte");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output register");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !found_reg) |-> (offset_reg == '0))
        else $error("nonzero offset without a match");

    a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg && !ctrl.clear) |=> (seen_reg && $stable(first_reg)))
        else $error("latched match changed inside a buffer");

    a_clear_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (count_reg == '0) && !seen_reg && (chain_vec == '0))
        else $error("scan state not cleared after last byte");

endmodule

`default_nettype wire

FILE: bench/wildcard_byte_pattern_search_core_tb.sv
// self-checking bench for the wildcard byte pattern search core: directed table plus random buffers
`timescale 1ns / 100ps

module wildcard_byte_pattern_search_core_tb;

    import wbps_pkg::*;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
    } scan_result_t;

    typedef enum bit {ROW_WRITE, ROW_BYTE} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]    value;
        logic [7:0]               data;
        bit                       last;
        bit                       typed;
        bit                       found;
        logic [31:0]              offset;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata;   // data_byte
    logic                    s_axis_tlast;   // last_byte
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [39:0]             m_axis_tdata;   // found, match_offset, pad

    wildcard_byte_pattern_search_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor copy of configuration and scan state
    logic [63:0]  pat_low;
    logic [63:0]  pat_high;
    logic [15:0]  wild_mask;
    logic [4:0]   pat_len;
    logic [7:0]   history [0:14];
    logic [31:0]  bytes_seen;
    bit           match_latched;
    logic [31:0]  first_offset;

    scan_result_t pending_results [$];
    plan_row_t    plan [$];
    logic [7:0]   scan_buf [$];
    int unsigned  errors;
    int unsigned  bytes_sent;
    bit           idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] pattern_byte(input int unsigned i);
        if (i < 8)
            return pat_low[8*i +: 8];
        return pat_high[8*(i-8) +: 8];
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic plan_row_t row_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [63:0] value);
        plan_row_t row;
        row = '{ROW_WRITE, idx, value, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0};
        return row;
    endfunction

    function automatic plan_row_t row_byte(input logic [7:0] data, input bit last);
        plan_row_t row;
        row = '{ROW_BYTE, '0, 64'd0, data, last, 1'b0, 1'b0, 32'd0};
        return row;
    endfunction

    function automatic plan_row_t row_result(input logic [7:0] data, input bit found,
                                             input logic [31:0] offset);
        plan_row_t row;
        row = '{ROW_BYTE, '0, 64'd0, data, 1'b1, 1'b1, found, offset};
        return row;
    endfunction

    task automatic add_row(input plan_row_t row);
        plan.insert(plan.size(), row);
    endtask

    task automatic clear_scan();
        for (int i = 0; i < 15; i++)
            history[i] = 8'h00;
        bytes_seen    = 32'd0;
        match_latched = 1'b0;
        first_offset  = 32'd0;
    endtask

    task automatic scan_step(input logic [7:0] data, input bit last,
                             output bit has_result, output scan_result_t result);
        int unsigned len;
        bit          ok;
        logic [7:0]  cand;
        len = 32'(pat_len);
        has_result = 1'b0;
        result = '0;
        if (len >= 1 && len <= 16 && !match_latched && bytes_seen >= len - 1)
        begin
            ok = 1'b1;
            for (int unsigned i = 0; i < len; i++)
            begin
                cand = (i == len - 1) ? data : history[len - 2 - i];
                if (!wild_mask[i] && cand != pattern_byte(i))
                    ok = 1'b0;
            end
            if (ok)
            begin
                match_latched = 1'b1;
                first_offset  = bytes_seen - (len - 1);
            end
        end
        if (last)
        begin
            has_result    = 1'b1;
            result.found  = match_latched;
            result.offset = match_latched ? first_offset : 32'd0;
            clear_scan();
        end
        else
        begin
            for (int i = 14; i > 0; i--)
                history[i] = history[i-1];
            history[0] = data;
            if (bytes_seen != 32'hFFFF_FFFF)
                bytes_seen = bytes_seen + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PATTERN_LOW:  pat_low   = value;
            REG_PATTERN_HIGH: pat_high  = value;
            REG_WILDCARD:     wild_mask = value[15:0];
            REG_LENGTH:       pat_len   = value[4:0];
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] data, input bit last, input bit typed,
                             input bit found, input logic [31:0] offset);
        int unsigned  gap;
        bit           has_result;
        scan_result_t result;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scan_step(data, last, has_result, result);
        if (has_result)
        begin
            if (typed)
            begin
                result.found  = found;
                result.offset = offset;
            end
            pending_results.insert(pending_results.size(), result);
        end
        bytes_sent++;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", m_axis_tdata[32:1], 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.found)
                    report_mismatch("found", 32'(m_axis_tdata[0]), 32'(want.found));
                if (m_axis_tdata[32:1] !== want.offset)
                    report_mismatch("match_offset", m_axis_tdata[32:1], want.offset);
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int unsigned n;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = pick_gap();
            if (n != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        bit           prev_write;
        int unsigned  stop_at;
        int unsigned  len;
        int unsigned  blen;
        int unsigned  pos;
        int unsigned  r;
        logic [15:0]  mask;
        logic [63:0]  word;
        bit           from_pattern;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        errors        = 0;
        bytes_sent    = 0;
        idle_on       = 1'b1;
        pat_low       = '0;
        pat_high      = '0;
        wild_mask     = '0;
        pat_len       = '0;
        clear_scan();

        // zero length, then pattern ab ?? cd with junk in unused register bits
        add_row(row_result(8'h00, 1'b0, 32'd0));
        add_row(row_byte(8'hFF, 1'b0));
        add_row(row_result(8'hAB, 1'b0, 32'd0));
        add_row(row_write(REG_PATTERN_LOW,  64'hFFFF_FFFF_FFCD_55AB));
        add_row(row_write(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF));
        add_row(row_write(REG_WILDCARD,     64'hFFFF_FFFF_FFFF_0002));
        add_row(row_write(REG_LENGTH,       64'hFFFF_FFFF_FFFF_FFE3));
        add_row(row_byte(8'h11, 1'b0));
        add_row(row_byte(8'hAB, 1'b0));
        add_row(row_byte(8'h99, 1'b0));
        add_row(row_result(8'hCD, 1'b1, 32'd1));
        // two matches, first one latched
        add_row(row_byte(8'hAB, 1'b0));
        add_row(row_byte(8'h00, 1'b0));
        add_row(row_byte(8'hCD, 1'b0));
        add_row(row_byte(8'hAB, 1'b0));
        add_row(row_byte(8'h01, 1'b0));
        add_row(row_result(8'hCD, 1'b1, 32'd0));
        // buffer shorter than pattern
        add_row(row_byte(8'hAB, 1'b0));
        add_row(row_result(8'hCD, 1'b0, 32'd0));
        // single all-wildcard byte
        add_row(row_write(REG_WILDCARD, 64'h0000_0000_0000_FFFF));
        add_row(row_write(REG_LENGTH,   64'd1));
        add_row(row_result(8'hFF, 1'b1, 32'd0));
        add_row(row_byte(8'h00, 1'b0));
        add_row(row_result(8'h00, 1'b1, 32'd0));
        // length above maximum
        add_row(row_write(REG_LENGTH, 64'd17));
        add_row(row_byte(8'h12, 1'b0));
        add_row(row_result(8'h34, 1'b0, 32'd0));
        // all-zero registers, full length
        add_row(row_write(REG_PATTERN_LOW,  64'd0));
        add_row(row_write(REG_PATTERN_HIGH, 64'd0));
        add_row(row_write(REG_WILDCARD,     64'd0));
        add_row(row_write(REG_LENGTH,       64'd16));
        add_row(row_result(8'h00, 1'b0, 32'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_write = 1'b0;
        foreach (plan[n])
        begin
            if (plan[n].kind == ROW_WRITE)
            begin
                if (!prev_write)
                    wait_drain();
                cfg_write(plan[n].index, plan[n].value);
                prev_write = 1'b1;
            end
            else
            begin
                if (prev_write)
                    cfg_valid <= 1'b0;
                send_byte(plan[n].data, plan[n].last, plan[n].typed, plan[n].found,
                          plan[n].offset);
                prev_write = 1'b0;
            end
        end

        stop_at = bytes_sent + 1850;
        while (bytes_sent < stop_at)
        begin
            wait_drain();
            idle_on = ($urandom_range(0, 3) != 0);

            r = $urandom_range(0, 99);
            if (r < 5)
                len = 0;
            else if (r < 12)
                len = $urandom_range(17, 31);
            else if (r < 20)
                len = 16;
            else if (r < 60)
                len = $urandom_range(1, 4);
            else
                len = $urandom_range(1, 16);

            r = $urandom_range(0, 99);
            if (r < 40)
                mask = 16'h0000;
            else if (r < 70)
                mask = 16'($urandom & $urandom & $urandom);
            else if (r < 92)
                mask = 16'($urandom);
            else
                mask = 16'hFFFF;

            cfg_write(REG_PATTERN_LOW,  {$urandom, $urandom});
            cfg_write(REG_PATTERN_HIGH, {$urandom, $urandom});
            word = {$urandom, $urandom};
            word[15:0] = mask;
            cfg_write(REG_WILDCARD, word);
            word = {$urandom, $urandom};
            word[4:0] = 5'(len);
            cfg_write(REG_LENGTH, word);
            cfg_valid <= 1'b0;

            repeat ($urandom_range(1, 8))
            begin
                if (bytes_sent < stop_at)
                begin
                    blen = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24)
                                                      : $urandom_range(25, 200);
                    if (blen > stop_at - bytes_sent)
                        blen = stop_at - bytes_sent;
                    from_pattern = ($urandom_range(0, 99) < 60);
                    scan_buf.delete();
                    for (int unsigned i = 0; i < blen; i++)
                    begin
                        if (from_pattern && $urandom_range(0, 1))
                            scan_buf.insert(scan_buf.size(),
                                            pattern_byte($urandom_range(0, 15)));
                        else
                            scan_buf.insert(scan_buf.size(), 8'($urandom));
                    end
                    if (len >= 1 && len <= 16 && blen >= len && $urandom_range(0, 99) < 75)
                    begin
                        repeat ($urandom_range(1, 2))
                        begin
                            pos = $urandom_range(0, blen - len);
                            for (int unsigned i = 0; i < len; i++)
                                scan_buf[pos + i] = wild_mask[i] ? 8'($urandom)
                                                                 : pattern_byte(i);
                        end
                    end
                    foreach (scan_buf[i])
                        send_byte(scan_buf[i], i == blen - 1, 1'b0, 1'b0, 32'd0);
                end
            end
        end

        wait_drain();
        repeat (6) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
